// File: hdl/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue core.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_READ_POS   = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [31:0] push_value;
    logic [3:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    status_t            status;
    logic [4:0]         fill_count;
  } rsp_t;

  typedef struct packed {
    logic  shift_back;
    logic  shift_front;
    logic  load_back;
    idx_t  back_index;
    word_t value;
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: hdl/dq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_cell
// One queue slot; shifts toward either neighbor or loads the pushed word.
// ----------------------------------------------------------------------------
module dq_cell (
  input  wire logic              clk,
  input  wire dq_pkg::idx_t      index,
  input  wire dq_pkg::cell_cmd_t cmd,
  input  wire dq_pkg::word_t     prev_word,
  input  wire dq_pkg::word_t     next_word,
  output dq_pkg::word_t          word
);

  always_ff @(posedge clk) begin
    if (cmd.shift_back) begin
      word <= prev_word;
    end else if (cmd.shift_front) begin
      word <= next_word;
    end else if (cmd.load_back && (cmd.back_index == index)) begin
      word <= cmd.value;
    end
  end

endmodule
`default_nettype wire

// File: hdl/dq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Fill count, request decode, cell commands and result formation.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire dq_pkg::req_t      req,
  input  wire dq_pkg::word_t     front_word,
  input  wire dq_pkg::word_t     sel_word,
  output dq_pkg::idx_t           sel_index,
  output dq_pkg::cell_cmd_t      cmd,
  output dq_pkg::rsp_t           rsp_next
);

  dq_pkg::cnt_t count;
  dq_pkg::cnt_t count_next;
  logic         is_full;
  logic         is_empty;
  logic         pos_over;
  dq_pkg::idx_t back_index;

  function automatic logic [31:0] widen(dq_pkg::word_t w);
    logic signed [dq_pkg::WORD_WIDTH-1:0] ws;
    ws = $signed(w);
    return 32'(ws);
  endfunction

  assign is_full    = (count == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign is_empty   = (count == '0);
  assign pos_over   = (32'(req.position) >= 32'(count));
  assign back_index = dq_pkg::IDX_W'(count - dq_pkg::CNT_W'(1));
  assign sel_index  = (req.opcode == dq_pkg::OP_READ_POS) ?
                      dq_pkg::IDX_W'(req.position) : back_index;

  always_comb begin
    count_next          = count;
    cmd.shift_back      = 1'b0;
    cmd.shift_front     = 1'b0;
    cmd.load_back       = 1'b0;
    cmd.back_index      = dq_pkg::IDX_W'(count);
    cmd.value           = dq_pkg::word_t'(req.push_value);
    rsp_next.read_value = '0;
    rsp_next.status     = dq_pkg::ST_OK;
    if (start) begin
      case (req.opcode)
        dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            rsp_next.status = dq_pkg::ST_FULL;
          end else begin
            count_next = count + dq_pkg::CNT_W'(1);
            if (req.opcode == dq_pkg::OP_PUSH_FRONT) begin
              cmd.shift_back = 1'b1;
            end else begin
              cmd.load_back = 1'b1;
            end
          end
        end
        dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT: begin
          if (is_empty) begin
            rsp_next.status = dq_pkg::ST_EMPTY;
          end else begin
            rsp_next.read_value = widen(front_word);
            if (req.opcode == dq_pkg::OP_POP_FRONT) begin
              cmd.shift_front = 1'b1;
              count_next      = count - dq_pkg::CNT_W'(1);
            end
          end
        end
        dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK: begin
          if (is_empty) begin
            rsp_next.status = dq_pkg::ST_EMPTY;
          end else begin
            rsp_next.read_value = widen(sel_word);
            if (req.opcode == dq_pkg::OP_POP_BACK) begin
              count_next = count - dq_pkg::CNT_W'(1);
            end
          end
        end
        dq_pkg::OP_READ_POS: begin
          if (is_empty) begin
            rsp_next.status = dq_pkg::ST_EMPTY;
          end else if (pos_over) begin
            rsp_next.status = dq_pkg::ST_RANGE;
          end else begin
            rsp_next.read_value = widen(sel_word);
          end
        end
        default: begin
          count_next = '0;
        end
      endcase
    end
    rsp_next.fill_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/double_ended_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded deque built as a row of shifting cells, front word in the first cell.
// ----------------------------------------------------------------------------
// results: registered, shown in the cycle after the request, marked by done
// throughput: one request per cycle, busy stays low; set by the cell row update
// reset: synchronous, clears the fill count and done; cell contents are kept
// the receiver cannot stall, so every result shows for exactly one cycle
module double_ended_queue_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire dq_pkg::req_t req,
  output logic              done,
  output dq_pkg::rsp_t      rsp
);

  dq_pkg::word_t     cell_word [dq_pkg::DEPTH];
  dq_pkg::idx_t      sel_index;
  dq_pkg::cell_cmd_t cmd;
  dq_pkg::rsp_t      rsp_next;

  assign busy = 1'b0;

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .front_word (cell_word[0]),
    .sel_word   (cell_word[sel_index]),
    .sel_index  (sel_index),
    .cmd        (cmd),
    .rsp_next   (rsp_next)
  );

  for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
    dq_pkg::word_t prev_word;
    dq_pkg::word_t next_word;
    if (i == 0) begin : g_first
      assign prev_word = cmd.value;
    end else begin : g_mid
      assign prev_word = cell_word[i-1];
    end
    if (i == dq_pkg::DEPTH - 1) begin : g_last
      assign next_word = cell_word[i];
    end else begin : g_inner
      assign next_word = cell_word[i+1];
    end
    dq_cell u_cell (
      .clk       (clk),
      .index     (dq_pkg::IDX_W'(i)),
      .cmd       (cmd),
      .prev_word (prev_word),
      .next_word (next_word),
      .word      (cell_word[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule
`default_nettype wire

// File: dv/double_ended_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_tb
// Self-checking bench for the deque core. A short table of directed requests
// covers empty and full queues, word extremes, every opcode and out-of-range
// positions; a long run of random requests then drifts the queue between
// empty and full. Checks use a ring-store predictor or a row's fixed result.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;
  import dq_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int RANDOM_REQS    = 1300;

  typedef struct {
    req_t rq;
    int   reps;
    bit   fixed;
    rsp_t rs;
  } row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  req = '0;
  logic  busy;
  logic  done;
  rsp_t  rsp;

  // typed-in expectation that travels with a directed request
  logic  req_fixed = 1'b0;
  rsp_t  req_fixed_rsp = '0;

  word_t ring_words [DEPTH];
  idx_t  front_idx = '0;
  int    words_held = 0;

  rsp_t  pending_rsp [$];
  int    mismatches = 0;
  int    stall_cycles = 0;

  always #1 clk = ~clk;

  double_ended_queue_core dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  // applies one request to the ring store and returns the result it gives
  function automatic rsp_t deque_step(req_t r);
    rsp_t o;
    idx_t at;
    o.read_value = '0;
    o.status     = ST_OK;
    case (r.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (words_held >= DEPTH) begin
          o.status = ST_FULL;
        end else if (r.opcode == OP_PUSH_FRONT) begin
          front_idx = idx_t'((front_idx + DEPTH - 1) % DEPTH);
          ring_words[front_idx] = word_t'(r.push_value);
          words_held++;
        end else begin
          at = idx_t'((front_idx + words_held) % DEPTH);
          ring_words[at] = word_t'(r.push_value);
          words_held++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (words_held == 0) begin
          o.status = ST_EMPTY;
        end else begin
          if (r.opcode == OP_POP_FRONT || r.opcode == OP_PEEK_FRONT)
            at = front_idx;
          else
            at = idx_t'((front_idx + words_held - 1) % DEPTH);
          o.read_value = $signed(ring_words[at]);
          if (r.opcode == OP_POP_FRONT) begin
            front_idx = idx_t'((front_idx + 1) % DEPTH);
            words_held--;
          end else if (r.opcode == OP_POP_BACK) begin
            words_held--;
          end
        end
      end
      OP_READ_POS: begin
        if (words_held == 0) begin
          o.status = ST_EMPTY;
        end else if (int'(r.position) >= words_held) begin
          o.status = ST_RANGE;
        end else begin
          at = idx_t'((front_idx + r.position) % DEPTH);
          o.read_value = $signed(ring_words[at]);
        end
      end
      default: begin
        front_idx  = '0;
        words_held = 0;
      end
    endcase
    o.fill_count = 5'(words_held);
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error at %0t: %s got %0d, wanted %0d", $time, what, got, want);
    mismatches++;
  endtask

  // requests are taken and results checked on the same edge, request first
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (start && !busy) begin
        want = deque_step(req);
        if (req_fixed)
          want = req_fixed_rsp;
        pending_rsp.push_back(want);
      end
      if (done) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("result with no request outstanding, fill_count",
                          rsp.fill_count, 0);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.read_value !== want.read_value)
            report_mismatch("read_value", rsp.read_value, want.read_value);
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.fill_count !== want.fill_count)
            report_mismatch("fill_count", rsp.fill_count, want.fill_count);
        end
      end
    end
    if ((start && !busy) || done)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", stall_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic row_t row(op_t op, logic [31:0] v, logic [3:0] pos, int reps,
                               bit fixed, logic [31:0] rv, status_t st,
                               logic [4:0] cnt);
    row_t r;
    r.rq.opcode        = op;
    r.rq.push_value    = v;
    r.rq.position      = pos;
    r.reps             = reps;
    r.fixed            = fixed;
    r.rs.read_value    = rv;
    r.rs.status        = st;
    r.rs.fill_count    = cnt;
    return r;
  endfunction

  task automatic issue(req_t r, bit fixed, rsp_t fr);
    start         <= 1'b1;
    req           <= r;
    req_fixed     <= fixed;
    req_fixed_rsp <= fr;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  initial begin
    row_t  plan [$];
    row_t  cur;
    req_t  rq;
    rsp_t  none;
    bit    fill_mode;
    bit    quiet;
    int    r;
    none      = '0;
    fill_mode = 1'b1;
    quiet     = 1'b0;

    plan.push_back(row(OP_POP_FRONT,  '0, 4'd0, 1, 1, '0, ST_EMPTY, 5'd0));
    plan.push_back(row(OP_POP_BACK,   '0, 4'd0, 1, 1, '0, ST_EMPTY, 5'd0));
    plan.push_back(row(OP_PEEK_FRONT, '0, 4'd0, 1, 1, '0, ST_EMPTY, 5'd0));
    plan.push_back(row(OP_PEEK_BACK,  '0, 4'd0, 1, 1, '0, ST_EMPTY, 5'd0));
    plan.push_back(row(OP_READ_POS,   '0, 4'd0, 1, 1, '0, ST_EMPTY, 5'd0));
    plan.push_back(row(OP_READ_POS,   '0, 4'd15, 1, 1, '0, ST_EMPTY, 5'd0));
    plan.push_back(row(OP_CLEAR,      '0, 4'd0, 1, 1, '0, ST_OK, 5'd0));
    plan.push_back(row(OP_PUSH_BACK,  32'h7fffffff, 4'd0, 1, 1, '0, ST_OK, 5'd1));
    plan.push_back(row(OP_PUSH_FRONT, 32'h80000000, 4'd0, 1, 1, '0, ST_OK, 5'd2));
    plan.push_back(row(OP_PEEK_FRONT, '0, 4'd0, 1, 1, 32'h80000000, ST_OK, 5'd2));
    plan.push_back(row(OP_PEEK_BACK,  '0, 4'd0, 1, 1, 32'h7fffffff, ST_OK, 5'd2));
    plan.push_back(row(OP_READ_POS,   '0, 4'd0, 1, 1, 32'h80000000, ST_OK, 5'd2));
    plan.push_back(row(OP_READ_POS,   '0, 4'd1, 1, 1, 32'h7fffffff, ST_OK, 5'd2));
    plan.push_back(row(OP_READ_POS,   '0, 4'd2, 1, 1, '0, ST_RANGE, 5'd2));
    plan.push_back(row(OP_READ_POS,   '0, 4'd15, 1, 1, '0, ST_RANGE, 5'd2));
    plan.push_back(row(OP_PUSH_BACK,  32'hffffffff, 4'd0, 1, 1, '0, ST_OK, 5'd3));
    plan.push_back(row(OP_POP_FRONT,  '0, 4'd0, 1, 1, 32'h80000000, ST_OK, 5'd2));
    plan.push_back(row(OP_POP_BACK,   '0, 4'd0, 1, 1, 32'hffffffff, ST_OK, 5'd1));
    plan.push_back(row(OP_POP_BACK,   '0, 4'd0, 1, 1, 32'h7fffffff, ST_OK, 5'd0));
    // fill from the front so the ring wraps backwards
    plan.push_back(row(OP_PUSH_FRONT, 32'h5a5a0000, 4'd0, DEPTH, 0, '0, ST_OK, '0));
    plan.push_back(row(OP_PUSH_BACK,  32'h00000001, 4'd0, 1, 1, '0, ST_FULL, 5'd16));
    plan.push_back(row(OP_PUSH_FRONT, 32'h00000001, 4'd0, 1, 1, '0, ST_FULL, 5'd16));
    plan.push_back(row(OP_READ_POS,   '0, 4'd15, 1, 0, '0, ST_OK, '0));
    plan.push_back(row(OP_CLEAR,      '0, 4'd0, 1, 1, '0, ST_OK, 5'd0));
    plan.push_back(row(OP_POP_FRONT,  '0, 4'd0, 1, 1, '0, ST_EMPTY, 5'd0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      cur = plan[i];
      for (int k = 0; k < cur.reps; k++) begin
        rq = cur.rq;
        rq.push_value = cur.rq.push_value + k;
        issue(rq, cur.fixed, cur.rs);
        idle_for(pick_gap(1'b0));
      end
    end

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 64 == 0)
        quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 29) == 0)
        fill_mode = !fill_mode;
      r = $urandom_range(0, 99);
      if (r < 2)
        rq.opcode = OP_CLEAR;
      else if (r < (fill_mode ? 62 : 22))
        rq.opcode = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else if (r < 82)
        rq.opcode = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      else begin
        case ($urandom_range(0, 2))
          0:       rq.opcode = OP_PEEK_FRONT;
          1:       rq.opcode = OP_PEEK_BACK;
          default: rq.opcode = OP_READ_POS;
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       rq.push_value = 32'h7fffffff;
          1:       rq.push_value = 32'h80000000;
          2:       rq.push_value = '0;
          default: rq.push_value = '1;
        endcase
      end else begin
        rq.push_value = $urandom;
      end
      rq.position = 4'($urandom_range(0, $urandom_range(0, 15)));
      issue(rq, 1'b0, none);
      idle_for(pick_gap(quiet));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
